// ===== rtl/core/hcb_pkg.sv =====
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared types, request codes and parameter defaults for the Huffman builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

    localparam int DEF_NUM_SYMBOLS   = 256;
    localparam int DEF_COUNT_BITS    = 32;
    localparam int DEF_MAX_CODE_BITS = 32;

    localparam logic [1:0] KIND_COUNT  = 2'd0;
    localparam logic [1:0] KIND_BUILD  = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic [7:0] query_symbol;
    } t_req;

    typedef struct packed {
        logic [8:0]  distinct_symbols;
        logic        symbol_present;
        logic [31:0] code_bits;
        logic [5:0]  code_length;
        logic        depth_overflow;
    } t_rsp;

endpackage

// ===== rtl/core/huffman_code_builder.sv =====
// ----------------------------------------------------------------------------
// huffman_code_builder
// Byte frequency counter with an iterative Huffman code table builder.
// ----------------------------------------------------------------------------
// Usage: raise start with a request while busy is low. A count request reads
// the count memory, then writes the entry back, and returns nothing. A
// lookup reads the code table and pulses o_valid with the result in the
// cycle busy drops after the accept. A build walks all symbols through one
// sorted list memory with a single compare/add unit: each insert scans the
// list and shifts the tail one entry at a time, each shift a read then a
// write; after the merges comes a leaf-to-root walk, one tree level per
// step, for each present symbol. The result is shown for exactly one
// cycle on o_valid; the receiver cannot stall it, so capture it when it
// appears. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module huffman_code_builder
    import hcb_pkg::*;
#(
    parameter int NUM_SYMBOLS   = DEF_NUM_SYMBOLS,
    parameter int COUNT_BITS    = DEF_COUNT_BITS,
    parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_rsp o_rsp
);

    localparam int SYM_W = $clog2(NUM_SYMBOLS);
    localparam int NID_W = SYM_W + 1;           // node ids, list indexes, lengths
    localparam int NODES = 2 * NUM_SYMBOLS - 1;
    localparam int LDEP  = 2 ** NID_W;          // circular sorted list
    localparam int WT_W  = COUNT_BITS + SYM_W;

    typedef struct packed {
        logic [NID_W-1:0] id;
        logic [WT_W-1:0]  w;
    } t_ent;

    typedef struct packed {
        logic [NID_W-1:0] parent;
        logic             side;
    } t_par;

    typedef struct packed {
        logic [MAX_CODE_BITS-1:0] code;
        logic [5:0]               len;
    } t_tbl;

    typedef enum logic [4:0] {
        S_IDLE, S_CNT_WR, S_LK_OUT, S_B_INIT, S_B_RD, S_B_CHK,
        S_INS_RD, S_INS_CMP, S_SH_RD, S_SH_WR, S_INS_WR,
        S_MRG, S_MRG_A, S_MRG_B, S_MRG_B2, S_ROOT,
        S_C_SYM, S_C_WALK, S_C_UP, S_DONE
    } t_state;

    // memories
    logic [COUNT_BITS-1:0] cnt_mem [NUM_SYMBOLS];
    t_ent                  lst_mem [LDEP];
    t_par                  par_mem [NODES];
    t_tbl                  tbl_mem [NUM_SYMBOLS];

    logic [COUNT_BITS-1:0] r_cnt_rd;
    t_ent                  r_lst_rd;
    t_par                  r_par_rd;
    t_tbl                  r_tbl_rd;

    // control and datapath registers
    t_state                   r_state;
    logic [NUM_SYMBOLS-1:0]   r_cvld;     // count entry written since reset
    logic [NUM_SYMBOLS-1:0]   r_tvld;     // table entry written in last build
    logic [NUM_SYMBOLS-1:0]   r_pres;
    logic [SYM_W-1:0]         r_sym;
    logic [NID_W-1:0]         r_distinct;
    logic                     r_ovf;
    logic                     r_q_ok;
    logic                     r_merge;
    logic [NID_W-1:0]         r_head;
    logic [NID_W-1:0]         r_len;
    logic [NID_W-1:0]         r_pos;
    logic [NID_W-1:0]         r_k;
    logic [NID_W-1:0]         r_next;
    logic [NID_W-1:0]         r_root;
    logic [NID_W-1:0]         r_node;
    logic [NID_W-1:0]         r_depth;
    logic [MAX_CODE_BITS-1:0] r_code;
    t_ent                     r_new;
    t_ent                     r_a;
    logic [NID_W-1:0]         r_b_id;

    logic [COUNT_BITS-1:0] cnt_val;
    logic [SYM_W-1:0]      cnt_raddr;
    logic [SYM_W-1:0]      tbl_raddr;
    logic [NID_W-1:0]      lst_raddr;
    logic                  lst_we;
    logic [NID_W-1:0]      lst_waddr;
    t_ent                  lst_wdata;
    logic                  par_we;
    logic [NID_W-1:0]      par_waddr;
    t_par                  par_wdata;
    logic                  tbl_we;
    logic                  cnt_we;
    logic                  sym_last;
    logic                  at_root;
    logic                  in_range_b;
    logic                  in_range_q;

    assign busy       = (r_state != S_IDLE);
    assign cnt_val    = r_cvld[r_sym] ? r_cnt_rd : '0;
    assign sym_last   = (r_sym == SYM_W'(NUM_SYMBOLS - 1));
    assign at_root    = (r_node == r_root);
    assign in_range_b = ({1'b0, i_req.byte_value} < 9'(NUM_SYMBOLS));
    assign in_range_q = ({1'b0, i_req.query_symbol} < 9'(NUM_SYMBOLS));
    assign cnt_raddr  = (r_state == S_IDLE) ? i_req.byte_value[SYM_W-1:0] : r_sym;
    assign tbl_raddr  = i_req.query_symbol[SYM_W-1:0];
    assign cnt_we     = (r_state == S_CNT_WR) && (cnt_val != '1);
    assign tbl_we     = (r_state == S_C_WALK) && at_root
                        && (32'(r_depth) <= MAX_CODE_BITS);

    // memory port steering
    always_comb begin
        lst_we    = 1'b0;
        lst_waddr = r_head + r_pos;
        lst_wdata = r_new;
        par_we    = 1'b0;
        par_waddr = r_a.id;
        par_wdata = '{parent: r_next, side: 1'b0};
        unique case (r_state)
            S_INS_RD:  lst_raddr = r_head + r_pos;
            S_SH_RD:   lst_raddr = r_head + r_k - NID_W'(1);
            S_MRG_A:   lst_raddr = r_head + NID_W'(1);
            default:   lst_raddr = r_head;
        endcase
        unique case (r_state)
            S_SH_WR: begin
                lst_we    = 1'b1;
                lst_waddr = r_head + r_k;
                lst_wdata = r_lst_rd;
            end
            S_INS_WR: begin
                lst_we = 1'b1;
            end
            S_MRG_B: begin
                par_we = 1'b1;
            end
            S_MRG_B2: begin
                par_we    = 1'b1;
                par_waddr = r_b_id;
                par_wdata = '{parent: r_new.id, side: 1'b1};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cnt_rd <= cnt_mem[cnt_raddr];
        if (cnt_we) begin
            cnt_mem[r_sym] <= cnt_val + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_lst_rd <= lst_mem[lst_raddr];
        if (lst_we) begin
            lst_mem[lst_waddr] <= lst_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_par_rd <= par_mem[r_node];
        if (par_we) begin
            par_mem[par_waddr] <= par_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tbl_rd <= tbl_mem[tbl_raddr];
        if (tbl_we) begin
            tbl_mem[r_sym] <= '{code: r_code, len: 6'(r_depth)};
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cvld     <= '0;
            r_tvld     <= '0;
            r_pres     <= '0;
            r_distinct <= '0;
            r_ovf      <= 1'b0;
            r_len      <= '0;
            o_valid    <= 1'b0;
            o_rsp      <= '0;
        end else begin
            // raise the strobe for one cycle when a response is produced
            o_valid <= (r_state == S_LK_OUT) || (r_state == S_DONE);
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        unique case (i_req.kind)
                            KIND_COUNT: begin
                                r_sym <= i_req.byte_value[SYM_W-1:0];
                                if (in_range_b) begin
                                    r_state <= S_CNT_WR;
                                end
                            end
                            KIND_BUILD: r_state <= S_B_INIT;
                            KIND_LOOKUP: begin
                                r_sym   <= i_req.query_symbol[SYM_W-1:0];
                                r_q_ok  <= in_range_q;
                                r_state <= S_LK_OUT;
                            end
                            KIND_NONE: begin
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_CNT_WR: begin
                    if (cnt_val != '1) begin
                        r_cvld[r_sym] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_LK_OUT: begin
                    o_rsp <= '{
                        distinct_symbols: 9'(r_distinct),
                        symbol_present:   r_q_ok & r_pres[r_sym],
                        code_bits:        (r_q_ok && r_tvld[r_sym])
                                          ? 32'(r_tbl_rd.code) : 32'd0,
                        code_length:      (r_q_ok && r_tvld[r_sym])
                                          ? r_tbl_rd.len : 6'd0,
                        depth_overflow:   r_ovf
                    };
                    r_state <= S_IDLE;
                end
                S_B_INIT: begin
                    r_tvld     <= '0;
                    r_pres     <= '0;
                    r_distinct <= '0;
                    r_ovf      <= 1'b0;
                    r_len      <= '0;
                    r_head     <= '0;
                    r_sym      <= '0;
                    r_merge    <= 1'b0;
                    r_next     <= NID_W'(NUM_SYMBOLS);
                    r_state    <= S_B_RD;
                end
                S_B_RD: r_state <= S_B_CHK;
                S_B_CHK: begin
                    if (cnt_val != '0) begin
                        // new leaf: insert it by weight
                        r_pres[r_sym] <= 1'b1;
                        r_distinct    <= r_distinct + NID_W'(1);
                        r_new         <= '{id: NID_W'(r_sym), w: WT_W'(cnt_val)};
                        r_pos         <= '0;
                        r_state       <= S_INS_RD;
                    end else if (sym_last) begin
                        r_merge <= 1'b1;
                        r_state <= (r_len == '0) ? S_DONE : S_MRG;
                    end else begin
                        r_sym   <= r_sym + SYM_W'(1);
                        r_state <= S_B_RD;
                    end
                end
                S_INS_RD: begin
                    if (r_pos == r_len) begin
                        r_state <= S_INS_WR;
                    end else begin
                        r_state <= S_INS_CMP;
                    end
                end
                S_INS_CMP: begin
                    if (r_lst_rd.w < r_new.w) begin
                        r_pos   <= r_pos + NID_W'(1);
                        r_state <= S_INS_RD;
                    end else begin
                        r_k     <= r_len;
                        r_state <= S_SH_RD;
                    end
                end
                S_SH_RD: begin
                    r_state <= (r_k == r_pos) ? S_INS_WR : S_SH_WR;
                end
                S_SH_WR: begin
                    r_k     <= r_k - NID_W'(1);
                    r_state <= S_SH_RD;
                end
                S_INS_WR: begin
                    r_len <= r_len + NID_W'(1);
                    if (r_merge) begin
                        r_state <= S_MRG;
                    end else if (sym_last) begin
                        r_merge <= 1'b1;
                        r_state <= S_MRG;
                    end else begin
                        r_sym   <= r_sym + SYM_W'(1);
                        r_state <= S_B_RD;
                    end
                end
                S_MRG: begin
                    r_state <= (r_len >= NID_W'(2)) ? S_MRG_A : S_ROOT;
                end
                S_MRG_A: begin
                    r_a     <= r_lst_rd;
                    r_state <= S_MRG_B;
                end
                S_MRG_B: begin
                    r_b_id  <= r_lst_rd.id;
                    r_new   <= '{id: r_next, w: r_a.w + r_lst_rd.w};
                    r_next  <= r_next + NID_W'(1);
                    r_state <= S_MRG_B2;
                end
                S_MRG_B2: begin
                    r_head  <= r_head + NID_W'(2);
                    r_len   <= r_len - NID_W'(2);
                    r_pos   <= '0;
                    r_state <= S_INS_RD;
                end
                S_ROOT: begin
                    r_root  <= r_lst_rd.id;
                    r_sym   <= '0;
                    r_state <= S_C_SYM;
                end
                S_C_SYM: begin
                    if (r_pres[r_sym]) begin
                        r_node  <= NID_W'(r_sym);
                        r_depth <= '0;
                        r_code  <= '0;
                        r_state <= S_C_WALK;
                    end else if (sym_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_sym <= r_sym + SYM_W'(1);
                    end
                end
                S_C_WALK: begin
                    if (at_root) begin
                        if (32'(r_depth) > MAX_CODE_BITS) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_tvld[r_sym] <= 1'b1;
                        end
                        if (sym_last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_sym   <= r_sym + SYM_W'(1);
                            r_state <= S_C_SYM;
                        end
                    end else begin
                        r_state <= S_C_UP;
                    end
                end
                S_C_UP: begin
                    if (32'(r_depth) < MAX_CODE_BITS) begin
                        r_code <= r_code
                                  | (MAX_CODE_BITS'(r_par_rd.side) << r_depth);
                    end
                    r_depth <= r_depth + NID_W'(1);
                    r_node  <= r_par_rd.parent;
                    r_state <= S_C_WALK;
                end
                S_DONE: begin
                    o_rsp <= '{
                        distinct_symbols: 9'(r_distinct),
                        symbol_present:   1'b0,
                        code_bits:        32'd0,
                        code_length:      6'd0,
                        depth_overflow:   r_ovf
                    };
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    a_count_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.kind == KIND_COUNT) |=> !o_valid)
        else $error("count request produced a result");

    a_lookup_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.kind == KIND_LOOKUP) |-> ##2 o_valid)
        else $error("lookup result missing");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (32'(r_len) <= NUM_SYMBOLS))
        else $error("sorted list overran symbol count");
`endif

endmodule
